### design/plist_pkg.sv
package plist_pkg;

    // Request codes carried on req_type
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2
    } req_t;

    // Unassigned request code, refused as out of range
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Fixed port widths
    localparam int POS_W   = 16;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic ins;  // shift up from the position, load the new word there
        logic rem;  // shift down into the position
    } cell_cmd_t;

endpackage

### design/positional_list_engine.sv
// Ordered list of up to DEPTH words held in a row of cells, one word per cell.
// Each item inserts a word at a position (later words move up one cell),
// removes the word at a position (later words move down one cell) or reads the
// word at a position. Insert and remove clamp a position past the end to the
// end. The whole row shifts in the cycle an item is accepted, so one item is
// taken every clock; its result appears in the output register in the cycle after
// acceptance and the next item is accepted while that result waits, as long as
// the output register is free or being emptied in the same cycle. The read
// path is an AND-OR across all DEPTH cells, which sets the clock period.
module positional_list_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    req_type,
    input  logic [plist_pkg::POS_W-1:0]   position,
    input  logic [plist_pkg::WORD_W-1:0]  data_in,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [1:0]                    status,
    output logic [plist_pkg::WORD_W-1:0]  data_out,
    output logic [plist_pkg::COUNT_W-1:0] item_count
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic                          accept;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    plist_pkg::status_t            status_reg;
    plist_pkg::status_t            status_next;
    logic [plist_pkg::WORD_W-1:0]  data_reg;
    logic [plist_pkg::WORD_W-1:0]  data_next;
    logic [plist_pkg::COUNT_W-1:0] item_count_reg;

    plist_pkg::req_t               req;
    plist_pkg::cell_cmd_t          cmd;
    logic [plist_pkg::POS_W-1:0]   count_ext;
    logic [IDX_W-1:0]              sel_pos;
    logic                          take_word;
    logic [DATA_WIDTH-1:0]         word;
    logic [DATA_WIDTH-1:0]         values [DEPTH];
    logic [DATA_WIDTH-1:0]         taps   [DEPTH];
    logic [DATA_WIDTH-1:0]         sel_word;

    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;
    assign req       = plist_pkg::req_t'(req_type);
    assign count_ext = plist_pkg::POS_W'(count_reg);
    assign word      = DATA_WIDTH'(data_in);

    // Decode the item: clamp the position, check bounds, form the row command
    always_comb
    begin
        cmd         = '0;
        sel_pos     = position[IDX_W-1:0];
        take_word   = 1'b0;
        status_next = plist_pkg::ST_OK;
        count_next  = count_reg;
        case (req)
            plist_pkg::REQ_INSERT:
            begin
                if (count_reg == FULL_CNT)
                    status_next = plist_pkg::ST_FULL;
                else
                begin
                    if (position > count_ext)
                        sel_pos = count_reg[IDX_W-1:0];
                    cmd.ins    = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            plist_pkg::REQ_REMOVE:
            begin
                if (count_reg == '0)
                    status_next = plist_pkg::ST_EMPTY;
                else
                begin
                    if (position >= count_ext)
                        sel_pos = IDX_W'(count_reg - 1'b1);
                    cmd.rem    = accept;
                    take_word  = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            plist_pkg::REQ_READ:
            begin
                if (position >= count_ext)
                    status_next = plist_pkg::ST_RANGE;
                else
                    take_word = 1'b1;
            end
            default:
                status_next = plist_pkg::ST_RANGE;
        endcase
    end

    // Row of cells, each linked to its neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_val;
        logic [DATA_WIDTH-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = word;
        end
        else
        begin : g_mid_l
            assign left_val = values[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_val = values[i];
        end
        else
        begin : g_mid_r
            assign right_val = values[i+1];
        end

        plist_cell #(
            .INDEX      (i),
            .IDX_W      (IDX_W),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .pos   (sel_pos),
            .word  (word),
            .left  (left_val),
            .right (right_val),
            .value (values[i]),
            .tap   (taps[i])
        );
    end

    // Merge the read bus: only the selected cell drives a nonzero tap
    always_comb
    begin
        sel_word = '0;
        for (int i = 0; i < DEPTH; i++)
            sel_word = sel_word | taps[i];
    end

    assign data_next      = take_word ? plist_pkg::WORD_W'(sel_word) : '0;
    assign rsp_valid_next = accept | (rsp_valid_reg & rsp_stall);

    // Hold the count and the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    // Load the result register on each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            data_reg       <= data_next;
            item_count_reg <= plist_pkg::COUNT_W'(count_next);
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign data_out   = data_reg;
    assign item_count = item_count_reg;

    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("list count above capacity");

    // Every accepted item leaves a result in the output register
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted item produced no result");

    // An insert into a list with room grows the count by one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req == plist_pkg::REQ_INSERT && count_reg != FULL_CNT)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the list");

    // A full refusal reports a full list
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == plist_pkg::ST_FULL) |-> count_reg == FULL_CNT)
        else $error("full status with room in list");

endmodule

### design/plist_cell.sv
module plist_cell #(
    parameter int INDEX      = 0,
    parameter int IDX_W      = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  plist_pkg::cell_cmd_t          cmd,
    input  logic [IDX_W-1:0]              pos,
    input  logic [DATA_WIDTH-1:0]         word,
    input  logic [DATA_WIDTH-1:0]         left,
    input  logic [DATA_WIDTH-1:0]         right,
    output logic [DATA_WIDTH-1:0]         value,
    output logic [DATA_WIDTH-1:0]         tap
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  hit;

    assign hit = (MY_IDX == pos);

    // Pick the new entry: take from a neighbor, load the word, or hold
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (MY_IDX > pos)
                entry_next = left;
            else if (hit)
                entry_next = word;
        end
        else if (cmd.rem)
        begin
            if (MY_IDX >= pos)
                entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Drive the entry to the row neighbors and onto the read bus when selected
    assign value = entry_reg;
    assign tap   = hit ? entry_reg : '0;

endmodule
